FILE: hdl/hxd_pkg.sv
package hxd_pkg;

    // Character codes the decoder reacts to
    localparam logic [7:0] CHAR_ZERO    = 8'h30;  // '0'
    localparam logic [7:0] CHAR_NINE    = 8'h39;  // '9'
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;  // 'a'
    localparam logic [7:0] CHAR_LOWER_F = 8'h66;  // 'f'
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;  // 'A'
    localparam logic [7:0] CHAR_UPPER_F = 8'h46;  // 'F'
    localparam logic [7:0] CHAR_LOWER_X = 8'h78;  // 'x'
    localparam logic [7:0] CHAR_SPACE   = 8'h20;
    localparam logic [7:0] CHAR_TAB     = 8'h09;  // first of TAB, LF, VT, FF, CR
    localparam logic [7:0] CHAR_CR      = 8'h0D;
    localparam logic [3:0] LETTER_BASE  = 4'd10;

    localparam int unsigned DATA_W  = 8;
    localparam int unsigned TDATA_W = 16;

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_BAD_DIGIT = 2'd1,
        STATUS_ODD_PAIR  = 2'd2
    } hxd_status_t;

    // Raw characters seen in the current string, saturating
    typedef enum logic [1:0] {
        POS_FIRST  = 2'd0,
        POS_SECOND = 2'd1,
        POS_REST   = 2'd2
    } hxd_pos_t;

    typedef struct packed {
        logic       digit;
        logic       blank;
        logic [3:0] value;
    } hxd_class_t;

    typedef struct packed {
        logic              byte_valid;
        logic [DATA_W-1:0] data_byte;
        logic              end_of_string;
        hxd_status_t       status;
    } hxd_result_t;

endpackage

FILE: hdl/hxd_char_class.sv
module hxd_char_class (
    input  logic [7:0]         char_code,
    output hxd_pkg::hxd_class_t char_class
);

    logic is_dec;
    logic is_lower;
    logic is_upper;

    // Range compares for the three digit groups
    assign is_dec   = (char_code >= hxd_pkg::CHAR_ZERO)    && (char_code <= hxd_pkg::CHAR_NINE);
    assign is_lower = (char_code >= hxd_pkg::CHAR_LOWER_A) && (char_code <= hxd_pkg::CHAR_LOWER_F);
    assign is_upper = (char_code >= hxd_pkg::CHAR_UPPER_A) && (char_code <= hxd_pkg::CHAR_UPPER_F);

    // Space plus the TAB..CR control range
    assign char_class.blank = (char_code == hxd_pkg::CHAR_SPACE) ||
                              ((char_code >= hxd_pkg::CHAR_TAB) && (char_code <= hxd_pkg::CHAR_CR));
    assign char_class.digit = is_dec || is_lower || is_upper;

    // Nibble value; letters add ten to the offset from 'a' or 'A'
    always_comb begin
        if (is_lower) begin
            char_class.value = hxd_pkg::LETTER_BASE +
                               4'(char_code - hxd_pkg::CHAR_LOWER_A);
        end else if (is_upper) begin
            char_class.value = hxd_pkg::LETTER_BASE +
                               4'(char_code - hxd_pkg::CHAR_UPPER_A);
        end else begin
            char_class.value = char_code[3:0];
        end
    end

endmodule

FILE: hdl/hxd_step.sv
module hxd_step (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 advance,
    input  logic [7:0]           char_code,
    input  logic                 last_char,
    input  hxd_pkg::hxd_class_t  char_class,
    output hxd_pkg::hxd_result_t result
);

    hxd_pkg::hxd_pos_t pos_reg, pos_next;
    logic              zero_held_reg, zero_held_next;
    logic [3:0]        high_reg, high_next;
    logic              pend_reg, pend_next;
    logic              err_reg, err_next;

    logic       is_zero;
    logic       is_x;
    logic       first_zero;
    logic       prefix_x;
    logic       release_zero;
    logic       skip_take;
    logic       pre_pend;
    logic [3:0] pre_high;
    logic       got;
    logic [7:0] byte_out;
    logic       pend_final;

    assign is_zero = (char_code == hxd_pkg::CHAR_ZERO);
    assign is_x    = (char_code == hxd_pkg::CHAR_LOWER_X);

    // Prefix detection: a leading '0' is held, "0x" drops both characters
    assign first_zero   = (pos_reg == hxd_pkg::POS_FIRST) && is_zero;
    assign prefix_x     = (pos_reg == hxd_pkg::POS_SECOND) && zero_held_reg && is_x;
    assign release_zero = (pos_reg == hxd_pkg::POS_SECOND) && zero_held_reg && !is_x;
    assign skip_take    = first_zero || prefix_x;

    // A released '0' opens a pair before the current character is decoded
    assign pre_pend = release_zero ? 1'b1 : pend_reg;
    assign pre_high = release_zero ? 4'd0 : high_reg;

    // Decode the current character against the open pair
    always_comb begin
        got       = 1'b0;
        byte_out  = '0;
        err_next  = err_reg;
        pend_next = pre_pend;
        high_next = pre_high;
        if (!err_reg && !skip_take && !char_class.blank) begin
            if (!char_class.digit) begin
                err_next = 1'b1;
            end else if (pre_pend) begin
                got       = 1'b1;
                byte_out  = {pre_high, char_class.value};
                pend_next = 1'b0;
                high_next = 4'd0;
            end else begin
                pend_next = 1'b1;
                high_next = char_class.value;
            end
        end
    end

    // A '0' still held at the end counts as a lone digit
    assign pend_final = pend_next || (last_char && first_zero);

    always_comb begin
        result.byte_valid    = got;
        result.data_byte     = byte_out;
        result.end_of_string = last_char;
        if (err_next) begin
            result.status = hxd_pkg::STATUS_BAD_DIGIT;
        end else if (last_char && pend_final) begin
            result.status = hxd_pkg::STATUS_ODD_PAIR;
        end else begin
            result.status = hxd_pkg::STATUS_OK;
        end
    end

    // Advance the character position, saturating
    always_comb begin
        unique case (pos_reg)
            hxd_pkg::POS_FIRST:  pos_next = hxd_pkg::POS_SECOND;
            hxd_pkg::POS_SECOND: pos_next = hxd_pkg::POS_REST;
            hxd_pkg::POS_REST:   pos_next = hxd_pkg::POS_REST;
            default:             pos_next = hxd_pkg::POS_REST;
        endcase
    end

    assign zero_held_next = first_zero;

    // Update string state per transaction; clear it after the final character
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg       <= hxd_pkg::POS_FIRST;
            zero_held_reg <= 1'b0;
            high_reg      <= 4'd0;
            pend_reg      <= 1'b0;
            err_reg       <= 1'b0;
        end else if (advance) begin
            if (last_char) begin
                pos_reg       <= hxd_pkg::POS_FIRST;
                zero_held_reg <= 1'b0;
                high_reg      <= 4'd0;
                pend_reg      <= 1'b0;
                err_reg       <= 1'b0;
            end else begin
                pos_reg       <= pos_next;
                zero_held_reg <= zero_held_next;
                high_reg      <= high_next;
                pend_reg      <= pend_next;
                err_reg       <= err_next;
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_clear_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && last_char |=>
            (pos_reg == hxd_pkg::POS_FIRST) && !pend_reg && !err_reg && !zero_held_reg)
        else $error("string state not cleared after final character");

    a_held_zero_alone: assert property (@(posedge aclk) disable iff (!aresetn)
        zero_held_reg |-> (pos_reg == hxd_pkg::POS_SECOND) && !pend_reg && !err_reg)
        else $error("held zero coexists with other string state");

    a_no_byte_on_error: assert property (@(posedge aclk) disable iff (!aresetn)
        err_reg |-> !got)
        else $error("byte produced after invalid digit");
`endif

endmodule

FILE: hdl/hex_text_to_byte_decoder.sv
// Hex text to byte decoder.
// The slave channel takes one character per transaction: s_axis_tdata holds the
// character code, s_axis_tlast marks the final character of a string. A leading
// "0x" is dropped, whitespace is skipped, and each pair of hex digits becomes a
// byte, first digit in the high nibble.
// The master channel returns exactly one transaction per character: tuser says
// whether tdata carries a completed byte, tdata also carries the status (ok,
// invalid digit, incomplete pair) and tlast marks the result of the final
// character, whose status is the outcome for the whole string.
// Each character passes through two registers: the input register, then the decode
// logic into the result register. Throughput is one character per cycle while the
// receiver accepts results, set by the single decode pass between the two registers.
// When the receiver stalls, the result register holds and the input register
// still takes one more character; s_axis_tready falls only when both are full.
// Reset clears both registers and the string state, so the next character is
// treated as the start of a new string.
module hex_text_to_byte_decoder (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [7:0]                  s_axis_tdata,   // [7:0] char_code
    input  logic                        s_axis_tlast,   // last_char
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [hxd_pkg::TDATA_W-1:0] m_axis_tdata,   // [7:0] data_byte, [9:8] status
    output logic                        m_axis_tuser,   // byte_valid
    output logic                        m_axis_tlast    // end_of_string
);

    logic                 in_valid_reg;
    logic [7:0]           in_char_reg;
    logic                 in_last_reg;
    logic                 out_valid_reg;
    hxd_pkg::hxd_result_t out_reg;
    logic                 out_free;
    logic                 advance;
    hxd_pkg::hxd_class_t  char_class;
    hxd_pkg::hxd_result_t result;

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign advance       = in_valid_reg && out_free;
    assign s_axis_tready = !in_valid_reg || advance;

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_axis_tready) begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            in_char_reg <= s_axis_tdata;
            in_last_reg <= s_axis_tlast;
        end
    end

    hxd_char_class u_class (
        .char_code  (in_char_reg),
        .char_class (char_class)
    );

    hxd_step u_step (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .advance    (advance),
        .char_code  (in_char_reg),
        .last_char  (in_last_reg),
        .char_class (char_class),
        .result     (result)
    );

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_reg <= result;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_reg.byte_valid;
    assign m_axis_tlast  = out_reg.end_of_string;
    assign m_axis_tdata  = {(hxd_pkg::TDATA_W - hxd_pkg::DATA_W - 2)'(0),
                            out_reg.status, out_reg.data_byte};

`ifndef NO_ASSERTIONS
    a_idle_byte_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tuser |-> (m_axis_tdata[7:0] == 8'd0))
        else $error("data byte not zero without a completed byte");

    a_odd_only_at_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && (m_axis_tdata[9:8] == hxd_pkg::STATUS_ODD_PAIR) |-> m_axis_tlast)
        else $error("incomplete pair reported before final character");

    a_status_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> (m_axis_tdata[9:8] != 2'd3))
        else $error("undefined status code");
`endif

endmodule
